// ===== sv/ssi_pkg.sv =====
// Shared constants and status codes for the segment intersection pipeline.
package ssi_pkg;

  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PT_W        = 32;
  localparam int unsigned OUT_TDATA_W = ((STATUS_W + 2 * PT_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

endpackage

// ===== sv/ssi_front.sv =====
// Front stages: differences, determinant, cross terms and scaled numerators.
module ssi_front import ssi_pkg::*; #(
  parameter int unsigned CW = 16,
  parameter int unsigned FB = 16,
  parameter int unsigned DETW = 2 * CW + 3,
  parameter int unsigned NS = 3 * CW + 3 + FB
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [8*CW-1:0]      in_coords,
  output logic                 out_valid,
  output logic [NS-1:0]        out_numx,
  output logic [NS-1:0]        out_numy,
  output logic                 out_negx,
  output logic                 out_negy,
  output logic [DETW-1:0]      out_dm,
  output logic [8*CW:0]        out_tag
);

  localparam int unsigned DW  = CW + 1;
  localparam int unsigned MDW = 2 * DW;
  localparam int unsigned MCW = 2 * CW;
  localparam int unsigned PW  = 2 * CW + 1;
  localparam int unsigned MNW = PW + DW;
  localparam int unsigned NW  = MNW + 1;

  logic [4:0] v_r;

  // Stage 1: coordinates and differences.
  logic [8*CW-1:0]       c1_r, c2_r, c3_r, c4_r;
  logic signed [CW-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [DW-1:0]  dx12_r, dy12_r, dx34_r, dy34_r;
  logic signed [DW-1:0]  dx12_nxt, dy12_nxt, dx34_nxt, dy34_nxt;

  assign x1 = in_coords[0*CW +: CW];
  assign y1 = in_coords[1*CW +: CW];
  assign x2 = in_coords[2*CW +: CW];
  assign y2 = in_coords[3*CW +: CW];
  assign x3 = in_coords[4*CW +: CW];
  assign y3 = in_coords[5*CW +: CW];
  assign x4 = in_coords[6*CW +: CW];
  assign y4 = in_coords[7*CW +: CW];

  assign dx12_nxt = DW'(x1) - DW'(x2);
  assign dy12_nxt = DW'(y1) - DW'(y2);
  assign dx34_nxt = DW'(x3) - DW'(x4);
  assign dy34_nxt = DW'(y3) - DW'(y4);

  // Stage 2: first products.
  logic signed [CW-1:0]  sx1, sy1, sx2, sy2, sx3, sy3, sx4, sy4;
  logic signed [MDW-1:0] md1_r, md2_r;
  logic signed [MCW-1:0] mp1_r, mp2_r, mq1_r, mq2_r;
  logic signed [DW-1:0]  e_dx12_r, e_dy12_r, e_dx34_r, e_dy34_r;

  assign sx1 = c1_r[0*CW +: CW];
  assign sy1 = c1_r[1*CW +: CW];
  assign sx2 = c1_r[2*CW +: CW];
  assign sy2 = c1_r[3*CW +: CW];
  assign sx3 = c1_r[4*CW +: CW];
  assign sy3 = c1_r[5*CW +: CW];
  assign sx4 = c1_r[6*CW +: CW];
  assign sy4 = c1_r[7*CW +: CW];

  // Stage 3: determinant and cross terms.
  logic signed [DETW-1:0] det_r, det_nxt;
  logic signed [PW-1:0]   pre_r, post_r;
  logic signed [DW-1:0]   f_dx12_r, f_dy12_r, f_dx34_r, f_dy34_r;

  assign det_nxt = DETW'(md1_r) - DETW'(md2_r);

  // Stage 4: second products.
  logic signed [MNW-1:0]  a1_r, a2_r, b1_r, b2_r;
  logic signed [DETW-1:0] det4_r;

  // Stage 5: numerators, magnitudes and signs.
  logic signed [NW-1:0]   nx, ny;
  logic signed [NS-1:0]   shx, shy;
  logic [NS-1:0]          numx_r, numy_r;
  logic                   negx_r, negy_r, par_r;
  logic [DETW-1:0]        dm_r;

  assign nx  = NW'(a1_r) - NW'(a2_r);
  assign ny  = NW'(b1_r) - NW'(b2_r);
  assign shx = NS'(nx) <<< FB;
  assign shy = NS'(ny) <<< FB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= in_coords;
      dx12_r <= dx12_nxt;
      dy12_r <= dy12_nxt;
      dx34_r <= dx34_nxt;
      dy34_r <= dy34_nxt;

      c2_r     <= c1_r;
      md1_r    <= MDW'(dx12_r) * MDW'(dy34_r);
      md2_r    <= MDW'(dy12_r) * MDW'(dx34_r);
      mp1_r    <= MCW'(sx1) * MCW'(sy2);
      mp2_r    <= MCW'(sy1) * MCW'(sx2);
      mq1_r    <= MCW'(sx3) * MCW'(sy4);
      mq2_r    <= MCW'(sy3) * MCW'(sx4);
      e_dx12_r <= dx12_r;
      e_dy12_r <= dy12_r;
      e_dx34_r <= dx34_r;
      e_dy34_r <= dy34_r;

      c3_r     <= c2_r;
      det_r    <= det_nxt;
      pre_r    <= PW'(mp1_r) - PW'(mp2_r);
      post_r   <= PW'(mq1_r) - PW'(mq2_r);
      f_dx12_r <= e_dx12_r;
      f_dy12_r <= e_dy12_r;
      f_dx34_r <= e_dx34_r;
      f_dy34_r <= e_dy34_r;

      c4_r   <= c3_r;
      det4_r <= det_r;
      a1_r   <= MNW'(pre_r) * MNW'(f_dx34_r);
      a2_r   <= MNW'(f_dx12_r) * MNW'(post_r);
      b1_r   <= MNW'(pre_r) * MNW'(f_dy34_r);
      b2_r   <= MNW'(f_dy12_r) * MNW'(post_r);

      numx_r  <= shx[NS-1] ? NS'(-shx) : NS'(shx);
      numy_r  <= shy[NS-1] ? NS'(-shy) : NS'(shy);
      negx_r  <= shx[NS-1] ^ det4_r[DETW-1];
      negy_r  <= shy[NS-1] ^ det4_r[DETW-1];
      dm_r    <= det4_r[DETW-1] ? DETW'(-det4_r) : DETW'(det4_r);
      par_r   <= (det4_r == '0);
    end
  end

  logic [8*CW-1:0] c5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c5_r <= c4_r;
    end
  end

  assign out_valid = v_r[4];
  assign out_numx  = numx_r;
  assign out_numy  = numy_r;
  assign out_negx  = negx_r;
  assign out_negy  = negy_r;
  assign out_dm    = dm_r;
  assign out_tag   = {par_r, c5_r};

endmodule

// ===== sv/ssi_div.sv =====
// Two-lane restoring divider, one quotient bit per pipeline stage.
module ssi_div #(
  parameter int unsigned NS = 67,
  parameter int unsigned DW = 35,
  parameter int unsigned TW = 129
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NS-1:0] in_numx,
  input  logic [NS-1:0] in_numy,
  input  logic          in_negx,
  input  logic          in_negy,
  input  logic [DW-1:0] in_dm,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NS-1:0] out_qx,
  output logic [NS-1:0] out_qy,
  output logic          out_rnzx,
  output logic          out_rnzy,
  output logic          out_negx,
  output logic          out_negy,
  output logic [TW-1:0] out_tag
);

  logic          v_r   [NS];
  logic [NS-1:0] nx_r  [NS];
  logic [NS-1:0] ny_r  [NS];
  logic [NS-1:0] qx_r  [NS];
  logic [NS-1:0] qy_r  [NS];
  logic [DW-1:0] rx_r  [NS];
  logic [DW-1:0] ry_r  [NS];
  logic [DW-1:0] dm_r  [NS];
  logic          ngx_r [NS];
  logic          ngy_r [NS];
  logic [TW-1:0] tag_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          s_v, s_ngx, s_ngy;
    logic [NS-1:0] s_nx, s_ny, s_qx, s_qy;
    logic [DW-1:0] s_rx, s_ry, s_dm;
    logic [TW-1:0] s_tag;
    logic [DW:0]   tx, ty;
    logic [DW+1:0] subx, suby;
    logic          gex, gey;

    if (k == 0) begin : g_first
      assign s_v   = in_valid;
      assign s_nx  = in_numx;
      assign s_ny  = in_numy;
      assign s_qx  = '0;
      assign s_qy  = '0;
      assign s_rx  = '0;
      assign s_ry  = '0;
      assign s_dm  = in_dm;
      assign s_ngx = in_negx;
      assign s_ngy = in_negy;
      assign s_tag = in_tag;
    end else begin : g_next
      assign s_v   = v_r[k-1];
      assign s_nx  = nx_r[k-1];
      assign s_ny  = ny_r[k-1];
      assign s_qx  = qx_r[k-1];
      assign s_qy  = qy_r[k-1];
      assign s_rx  = rx_r[k-1];
      assign s_ry  = ry_r[k-1];
      assign s_dm  = dm_r[k-1];
      assign s_ngx = ngx_r[k-1];
      assign s_ngy = ngy_r[k-1];
      assign s_tag = tag_r[k-1];
    end

    assign tx   = {s_rx, s_nx[NS-1]};
    assign ty   = {s_ry, s_ny[NS-1]};
    assign subx = {1'b0, tx} - {2'b00, s_dm};
    assign suby = {1'b0, ty} - {2'b00, s_dm};
    assign gex  = !subx[DW+1];
    assign gey  = !suby[DW+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[k]  <= {s_nx[NS-2:0], 1'b0};
        ny_r[k]  <= {s_ny[NS-2:0], 1'b0};
        qx_r[k]  <= {s_qx[NS-2:0], gex};
        qy_r[k]  <= {s_qy[NS-2:0], gey};
        rx_r[k]  <= gex ? subx[DW-1:0] : tx[DW-1:0];
        ry_r[k]  <= gey ? suby[DW-1:0] : ty[DW-1:0];
        dm_r[k]  <= s_dm;
        ngx_r[k] <= s_ngx;
        ngy_r[k] <= s_ngy;
        tag_r[k] <= s_tag;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_qx    = qx_r[NS-1];
  assign out_qy    = qy_r[NS-1];
  assign out_rnzx  = (rx_r[NS-1] != '0);
  assign out_rnzy  = (ry_r[NS-1] != '0);
  assign out_negx  = ngx_r[NS-1];
  assign out_negy  = ngy_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

// ===== sv/ssi_back.sv =====
// Back stages: floor correction, bounding range test and result register.
module ssi_back import ssi_pkg::*; #(
  parameter int unsigned CW = 16,
  parameter int unsigned FB = 16,
  parameter int unsigned NS = 3 * CW + 3 + FB
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [NS-1:0]      in_qx,
  input  logic [NS-1:0]      in_qy,
  input  logic               in_rnzx,
  input  logic               in_rnzy,
  input  logic               in_negx,
  input  logic               in_negy,
  input  logic [8*CW:0]      in_tag,
  output logic               out_valid,
  output status_t            out_status,
  output logic [PT_W-1:0]    out_x,
  output logic [PT_W-1:0]    out_y
);

  localparam int unsigned QW = NS + 1;
  localparam int unsigned BW = CW + FB + 1;

  logic signed [QW-1:0] qex, qey, px_r, py_r;
  logic signed [CW-1:0] c [8];
  logic signed [BW-1:0] lo_r [4];
  logic signed [BW-1:0] hi_r [4];
  logic                 par_r, va_r, vb_r;

  assign qex = QW'({1'b0, in_qx}) + QW'(in_rnzx & in_negx);
  assign qey = QW'({1'b0, in_qy}) + QW'(in_rnzy & in_negy);

  for (genvar i = 0; i < 8; i++) begin : g_unpack
    assign c[i] = in_tag[i*CW +: CW];
  end

  // Pairs: x of first, x of second, y of first, y of second.
  logic signed [CW-1:0] pa [4];
  logic signed [CW-1:0] pb [4];
  assign pa[0] = c[0];
  assign pb[0] = c[2];
  assign pa[1] = c[4];
  assign pb[1] = c[6];
  assign pa[2] = c[1];
  assign pb[2] = c[3];
  assign pa[3] = c[5];
  assign pb[3] = c[7];

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= in_negx ? -qex : qex;
      py_r  <= in_negy ? -qey : qey;
      par_r <= in_tag[8*CW];
      for (int i = 0; i < 4; i++) begin
        lo_r[i] <= (pa[i] < pb[i]) ? (BW'(pa[i]) <<< FB) : (BW'(pb[i]) <<< FB);
        hi_r[i] <= (pa[i] < pb[i]) ? (BW'(pb[i]) <<< FB) : (BW'(pa[i]) <<< FB);
      end
    end
  end

  logic inside_all;
  assign inside_all = (px_r >= QW'(lo_r[0])) && (px_r <= QW'(hi_r[0])) &&
                      (px_r >= QW'(lo_r[1])) && (px_r <= QW'(hi_r[1])) &&
                      (py_r >= QW'(lo_r[2])) && (py_r <= QW'(hi_r[2])) &&
                      (py_r >= QW'(lo_r[3])) && (py_r <= QW'(hi_r[3]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (par_r) begin
        out_status <= ST_PARALLEL;
        out_x      <= '0;
        out_y      <= '0;
      end else if (!inside_all) begin
        out_status <= ST_OUTSIDE;
        out_x      <= '0;
        out_y      <= '0;
      end else begin
        out_status <= ST_HIT;
        out_x      <= px_r[PT_W-1:0];
        out_y      <= py_r[PT_W-1:0];
      end
    end
  end

  assign out_valid = vb_r;

endmodule

// ===== sv/segment_segment_intersection.sv =====
// Top level of the pipelined two-dimensional segment intersection unit.
//
// Input channel in_*: one beat carries both segments, eight signed
// COORD_BITS-wide endpoint coordinates packed in in_tdata. Output channel
// out_*: one beat per input beat, in order, with the status (hit, parallel
// or outside) and the intersection point in fixed point with FRAC_BITS
// fraction bits; the point is zero unless the status is hit.
// Each beat passes the front stages, the divider and the back stages;
// NS = 3*COORD_BITS + 3 + FRAC_BITS is the number of quotient bits the
// divider produces, one per stage. Throughput is one beat per cycle: a
// new pair enters every cycle while the output side keeps taking beats.
// Most of the pipeline depth lies in the divider.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; no result is presented until a beat enters.
module segment_segment_intersection import ssi_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // first_ax, first_ay, first_bx, first_by,
  // second_ax, second_ay, second_bx, second_by
  input  logic [8*COORD_BITS-1:0] in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status, out_x, out_y, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned DETW = 2 * COORD_BITS + 3;
  localparam int unsigned NS   = 3 * COORD_BITS + 3 + FRAC_BITS;
  localparam int unsigned TW   = 8 * COORD_BITS + 1;

  logic            en;
  logic            f_valid, d_valid;
  logic [NS-1:0]   f_numx, f_numy, d_qx, d_qy;
  logic            f_negx, f_negy, d_negx, d_negy, d_rnzx, d_rnzy;
  logic [DETW-1:0] f_dm;
  logic [TW-1:0]   f_tag, d_tag;
  status_t         status;
  logic [PT_W-1:0] pt_x, pt_y;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  ssi_front #(.CW(COORD_BITS), .FB(FRAC_BITS), .DETW(DETW), .NS(NS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_coords (in_tdata),
    .out_valid (f_valid),
    .out_numx  (f_numx),
    .out_numy  (f_numy),
    .out_negx  (f_negx),
    .out_negy  (f_negy),
    .out_dm    (f_dm),
    .out_tag   (f_tag)
  );

  ssi_div #(.NS(NS), .DW(DETW), .TW(TW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_numx   (f_numx),
    .in_numy   (f_numy),
    .in_negx   (f_negx),
    .in_negy   (f_negy),
    .in_dm     (f_dm),
    .in_tag    (f_tag),
    .out_valid (d_valid),
    .out_qx    (d_qx),
    .out_qy    (d_qy),
    .out_rnzx  (d_rnzx),
    .out_rnzy  (d_rnzy),
    .out_negx  (d_negx),
    .out_negy  (d_negy),
    .out_tag   (d_tag)
  );

  ssi_back #(.CW(COORD_BITS), .FB(FRAC_BITS), .NS(NS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (d_valid),
    .in_qx      (d_qx),
    .in_qy      (d_qy),
    .in_rnzx    (d_rnzx),
    .in_rnzy    (d_rnzy),
    .in_negx    (d_negx),
    .in_negy    (d_negy),
    .in_tag     (d_tag),
    .out_valid  (out_tvalid),
    .out_status (status),
    .out_x      (pt_x),
    .out_y      (pt_y)
  );

  assign out_tdata = OUT_TDATA_W'({pt_y, pt_x, status});

  // A result that is not a hit never carries a point.
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status != ST_HIT) |-> (pt_x == '0 && pt_y == '0))
    else $error("non-hit result carries a point");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (status == ST_HIT || status == ST_PARALLEL || status == ST_OUTSIDE))
    else $error("undefined status code");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented straight after reset");

  // A stalled result keeps its beat on the next cycle.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule
